// ===== hdl/neighbor_count_threshold_3x3_core_defines.svh =====
// Assertion macros for the checker of the 3x3 neighbor count threshold core.
// Used by hdl/ncth_checker.sv; no other dependencies.
`ifndef NEIGHBOR_COUNT_THRESHOLD_3X3_CORE_DEFINES_SVH
`define NEIGHBOR_COUNT_THRESHOLD_3X3_CORE_DEFINES_SVH

// Same-cycle implication.
`define NCTH_ASSERT_SAME(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication.
`define NCTH_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== hdl/ncth_pkg.sv =====
// Shared types, codes and helpers of the 3x3 neighbor count threshold core.
// No dependencies; used by every module of the block except ncth_fifo.
`default_nettype none

package ncth_pkg;

   localparam int IMAGE_WIDTH_BITS  = 11;
   localparam int IMAGE_HEIGHT_BITS = 16;
   localparam int THRESHOLD_BITS    = 4;
   localparam int MARK_BITS         = 16;
   localparam int PIXEL_BITS        = 16;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 16;
   localparam int COUNT_BITS        = 4;
   localparam int WINDOW_BITS       = 9;
   localparam int CMD_QUEUE_DEPTH   = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COUNT_THRESHOLD = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MARK_VALUE      = 2'd3;

   localparam logic [IMAGE_WIDTH_BITS-1:0]  RESET_IMAGE_WIDTH     = 11'd1024;
   localparam logic [IMAGE_HEIGHT_BITS-1:0] RESET_IMAGE_HEIGHT    = 16'd1024;
   localparam logic [THRESHOLD_BITS-1:0]    RESET_COUNT_THRESHOLD = 4'd3;
   localparam logic [MARK_BITS-1:0]         RESET_MARK_VALUE      = 16'd1000;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [1:0] EMIT_NONE      = 2'd0;
   localparam logic [1:0] EMIT_ROW_END   = 2'd1;
   localparam logic [1:0] EMIT_CENTER    = 2'd2;
   localparam logic [1:0] EMIT_FRAME_END = 2'd3;

   typedef struct packed {
      logic                         opcode;
      logic signed [PIXEL_BITS-1:0] pixel_value;
   } req_payload_type;

   typedef struct packed {
      logic [MARK_BITS-1:0] result_value;
      logic                 last_of_frame;
   } rsp_payload_type;

   typedef struct packed {
      logic [IMAGE_WIDTH_BITS-1:0]  image_width;
      logic [IMAGE_HEIGHT_BITS-1:0] image_height;
      logic [THRESHOLD_BITS-1:0]    count_threshold;
      logic [MARK_BITS-1:0]         mark_value;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic       top_valid;
      logic       bottom_from_pixel;
      logic       pixel_set;
      logic [1:0] emit;
   } cmd_ctrl_type;

   // Columns: bit 0 top row, bit 1 center row, bit 2 bottom row.
   function automatic logic [COUNT_BITS-1:0] count_set(input logic [2:0] left,
                                                       input logic [2:0] centre,
                                                       input logic [2:0] right);
      return COUNT_BITS'(left[0]) + COUNT_BITS'(left[1]) + COUNT_BITS'(left[2])
           + COUNT_BITS'(centre[0]) + COUNT_BITS'(centre[2])
           + COUNT_BITS'(right[0]) + COUNT_BITS'(right[1]) + COUNT_BITS'(right[2]);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ncth_front.sv =====
// Front end: accepts items, tracks column, row and drain position, issues commands.
// Depends on ncth_pkg.
`default_nettype none

module ncth_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ncth_pkg::cfg_type             cfg,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire ncth_pkg::req_payload_type     req_payload,
   output logic                               cmd_valid,
   output ncth_pkg::cmd_ctrl_type             cmd_ctrl,
   output logic [$clog2(MAX_WIDTH)-1:0]       cmd_addr,
   input  wire logic                          cmd_ready
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int EW_MIN = $clog2(MAX_WIDTH + 1);
   localparam int EW     = (EW_MIN > ncth_pkg::IMAGE_WIDTH_BITS) ? EW_MIN
                                                               : ncth_pkg::IMAGE_WIDTH_BITS;
   localparam int HW     = ncth_pkg::IMAGE_HEIGHT_BITS;

   function automatic logic [HW-1:0] sat_inc(input logic [HW-1:0] v);
      return (v == '1) ? v : v + HW'(1);
   endfunction

   logic [CW-1:0] col_ff, col_in;
   logic [HW-1:0] row_ff, row_in;
   logic [EW-1:0] dpos_ff, dpos_in;

   logic [EW-1:0] width_cfg_ext;
   logic [EW-1:0] eff_width;
   logic [HW-1:0] eff_height;
   logic          accept;
   logic          wrap;
   logic [CW-1:0] col_start;
   logic [HW-1:0] row_start;
   logic [EW-1:0] col_next_ext;
   logic          pixel_set;

   assign width_cfg_ext = EW'(cfg.image_width);

   always_comb begin
      priority if (width_cfg_ext == '0) begin
         eff_width = EW'(1);
      end else if (width_cfg_ext > EW'(MAX_WIDTH)) begin
         eff_width = EW'(MAX_WIDTH);
      end else begin
         eff_width = width_cfg_ext;
      end
   end

   assign eff_height   = (cfg.image_height == '0) ? HW'(1) : cfg.image_height;
   assign req_ready    = cmd_ready;
   assign accept       = req_valid && req_ready;
   assign wrap         = (EW'(col_ff) >= eff_width);
   assign col_start    = wrap ? '0 : col_ff;
   assign row_start    = wrap ? sat_inc(row_ff) : row_ff;
   assign col_next_ext = EW'(col_start) + EW'(1);
   assign pixel_set    = !req_payload.pixel_value[ncth_pkg::PIXEL_BITS-1]
                         && (req_payload.pixel_value != '0);

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      dpos_in   = dpos_ff;
      cmd_valid = 1'b0;
      cmd_ctrl  = '0;
      cmd_addr  = col_start;
      if (accept) begin
         if (req_payload.opcode == ncth_pkg::OP_PIXEL) begin
            col_in = col_start;
            row_in = row_start;
            if (row_start < eff_height) begin
               cmd_valid                  = 1'b1;
               cmd_ctrl.load              = 1'b1;
               cmd_ctrl.top_valid         = (row_start >= HW'(2));
               cmd_ctrl.bottom_from_pixel = 1'b1;
               cmd_ctrl.pixel_set         = pixel_set;
               priority if (col_start == '0 && row_start >= HW'(2)) begin
                  cmd_ctrl.emit = ncth_pkg::EMIT_ROW_END;
               end else if (col_start != '0 && row_start != '0) begin
                  cmd_ctrl.emit = ncth_pkg::EMIT_CENTER;
               end else begin
                  cmd_ctrl.emit = ncth_pkg::EMIT_NONE;
               end
               if (col_next_ext >= eff_width) begin
                  col_in = '0;
                  row_in = sat_inc(row_start);
               end else begin
                  col_in = col_next_ext[CW-1:0];
               end
            end
         end else if (row_ff >= eff_height) begin
            cmd_valid = 1'b1;
            if (dpos_ff < eff_width) begin
               cmd_ctrl.load              = 1'b1;
               cmd_ctrl.top_valid         = (eff_height >= HW'(2));
               cmd_ctrl.bottom_from_pixel = 1'b0;
               cmd_ctrl.pixel_set         = 1'b0;
               priority if (dpos_ff == '0 && eff_height >= HW'(2)) begin
                  cmd_ctrl.emit = ncth_pkg::EMIT_ROW_END;
               end else if (dpos_ff != '0) begin
                  cmd_ctrl.emit = ncth_pkg::EMIT_CENTER;
               end else begin
                  cmd_ctrl.emit = ncth_pkg::EMIT_NONE;
               end
               cmd_addr = dpos_ff[CW-1:0];
               dpos_in  = dpos_ff + EW'(1);
            end else begin
               cmd_ctrl.emit = ncth_pkg::EMIT_FRAME_END;
               col_in        = '0;
               row_in        = '0;
               dpos_in       = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         dpos_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         dpos_ff <= dpos_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ncth_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on nothing; widths come from its parameters.
`default_nettype none

module ncth_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic [WIDTH-1:0]      head_data
);

   localparam int PW   = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   assign full       = (count_ff == CNTW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNTW'(1);
         2'b01:   count_in = count_ff - CNTW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ncth_back.sv =====
// Back end: line buffers, 3x3 window, neighbor count and the result register.
// Depends on ncth_pkg.
`default_nettype none

module ncth_back #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic [ncth_pkg::THRESHOLD_BITS-1:0]       count_threshold,
   input  wire logic [ncth_pkg::MARK_BITS-1:0]            mark_value,
   input  wire logic                                      cmd_valid,
   input  wire ncth_pkg::cmd_ctrl_type                    cmd_ctrl,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]              cmd_addr,
   output logic                                           cmd_pop,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_ready,
   output ncth_pkg::rsp_payload_type                      rsp_payload
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WB = ncth_pkg::WINDOW_BITS;

   logic                      upper_mem  [MAX_WIDTH];
   logic                      middle_mem [MAX_WIDTH];

   logic                      e_valid_ff;
   ncth_pkg::cmd_ctrl_type    e_ctrl_ff;
   logic [CW-1:0]             e_addr_ff;
   logic                      rd_upper_ff;
   logic                      rd_middle_ff;
   logic                      byp_ff;
   logic                      byp_upper_ff;
   logic                      byp_middle_ff;
   logic [WB-1:0]             window_ff;
   logic                      rsp_valid_ff;
   ncth_pkg::rsp_payload_type rsp_payload_ff;

   logic                               e_has_result;
   logic                               out_free;
   logic                               e_fire;
   logic                               mid;
   logic                               upper_val;
   logic                               top;
   logic                               bottom;
   logic [2:0]                         col_new;
   logic [WB-1:0]                      win_new;
   logic [ncth_pkg::COUNT_BITS-1:0]    count_edge;
   logic [ncth_pkg::COUNT_BITS-1:0]    count_center;
   logic [ncth_pkg::COUNT_BITS-1:0]    count_sel;
   ncth_pkg::rsp_payload_type          result;

   assign e_has_result = (e_ctrl_ff.emit != ncth_pkg::EMIT_NONE);
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign e_fire       = e_valid_ff && (!e_has_result || out_free);
   assign cmd_pop      = cmd_valid && (!e_valid_ff || e_fire);

   assign mid       = byp_ff ? byp_middle_ff : rd_middle_ff;
   assign upper_val = byp_ff ? byp_upper_ff : rd_upper_ff;
   assign top       = e_ctrl_ff.top_valid ? upper_val : mid;
   assign bottom    = e_ctrl_ff.bottom_from_pixel ? e_ctrl_ff.pixel_set : mid;
   assign col_new   = {bottom, mid, top};
   assign win_new   = (e_addr_ff == '0) ? {3{col_new}} : {col_new, window_ff[WB-1:3]};

   assign count_edge   = ncth_pkg::count_set(window_ff[5:3], window_ff[8:6], window_ff[8:6]);
   assign count_center = ncth_pkg::count_set(win_new[2:0], win_new[5:3], win_new[8:6]);

   always_comb begin
      unique case (e_ctrl_ff.emit)
         ncth_pkg::EMIT_NONE:      count_sel = count_edge;
         ncth_pkg::EMIT_ROW_END:   count_sel = count_edge;
         ncth_pkg::EMIT_CENTER:    count_sel = count_center;
         ncth_pkg::EMIT_FRAME_END: count_sel = count_edge;
      endcase
      result.result_value  = (ncth_pkg::COUNT_BITS'(count_sel) > count_threshold)
                             ? mark_value : '0;
      result.last_of_frame = (e_ctrl_ff.emit == ncth_pkg::EMIT_FRAME_END);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         window_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd_pop) begin
            e_valid_ff <= 1'b1;
         end else if (e_fire) begin
            e_valid_ff <= 1'b0;
         end
         if (e_fire) begin
            if (e_ctrl_ff.emit == ncth_pkg::EMIT_FRAME_END) begin
               window_ff <= '0;
            end else if (e_ctrl_ff.load) begin
               window_ff <= win_new;
            end
         end
         if (e_fire && e_has_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         e_ctrl_ff     <= cmd_ctrl;
         e_addr_ff     <= cmd_addr;
         byp_ff        <= e_fire && e_ctrl_ff.load && (e_addr_ff == cmd_addr);
         byp_upper_ff  <= mid;
         byp_middle_ff <= bottom;
      end
      if (e_fire && e_has_result) begin
         rsp_payload_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rd_upper_ff  <= upper_mem[cmd_addr];
         rd_middle_ff <= middle_mem[cmd_addr];
      end
      if (e_fire && e_ctrl_ff.load) begin
         upper_mem[e_addr_ff]  <= mid;
         middle_mem[e_addr_ff] <= bottom;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ===== hdl/neighbor_count_threshold_3x3_core.sv =====
// Top level of the 3x3 neighbor count threshold core: settings registers, front end,
// command queue and back end. Depends on ncth_pkg, ncth_front, ncth_fifo, ncth_back.
//
// Pixels enter on the req_ channel in raster order (opcode pixel); after the last
// pixel of a frame, width + 1 drain items (opcode drain) flush the remaining results,
// the last one flagged with last_of_frame. Each item yields at most one result on the
// rsp_ channel; pixel results lag the stream by one row plus one pixel.
// Throughput is one item per clock while the receiver keeps rsp_ready high. An
// accepted item passes the command queue, the execute register (loaded with the
// registered line buffer read feeding the window) and the result register. When
// rsp_ready stays low the result register holds, the back end stops, the four-entry
// command queue fills, and req_ready drops once it is full. Settings are written
// through csr_ with a single-cycle write, by the user only while the block is idle;
// the block does not enforce this. Reset restores the default settings, empties the
// queue and clears the counters and the window; the line buffers are not cleared and
// need no clearing pass, since the first rows of a frame overwrite them before use.
`default_nettype none

module neighbor_count_threshold_3x3_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire ncth_pkg::req_payload_type             req_payload,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output ncth_pkg::rsp_payload_type                  rsp_payload,
   input  wire logic                                  csr_write_en,
   input  wire logic [ncth_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [ncth_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int QW = $bits(ncth_pkg::cmd_ctrl_type) + CW;

   ncth_pkg::cfg_type      cfg_ff;

   logic                   cmd_valid;
   ncth_pkg::cmd_ctrl_type cmd_ctrl;
   logic [CW-1:0]          cmd_addr;
   logic                   q_full;
   logic                   q_valid;
   logic [QW-1:0]          q_head;
   logic                   q_pop;
   ncth_pkg::cmd_ctrl_type q_ctrl;
   logic [CW-1:0]          q_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width     <= ncth_pkg::RESET_IMAGE_WIDTH;
         cfg_ff.image_height    <= ncth_pkg::RESET_IMAGE_HEIGHT;
         cfg_ff.count_threshold <= ncth_pkg::RESET_COUNT_THRESHOLD;
         cfg_ff.mark_value      <= ncth_pkg::RESET_MARK_VALUE;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ncth_pkg::CSR_IMAGE_WIDTH:
               cfg_ff.image_width <= csr_wdata[ncth_pkg::IMAGE_WIDTH_BITS-1:0];
            ncth_pkg::CSR_IMAGE_HEIGHT:
               cfg_ff.image_height <= csr_wdata[ncth_pkg::IMAGE_HEIGHT_BITS-1:0];
            ncth_pkg::CSR_COUNT_THRESHOLD:
               cfg_ff.count_threshold <= csr_wdata[ncth_pkg::THRESHOLD_BITS-1:0];
            ncth_pkg::CSR_MARK_VALUE:
               cfg_ff.mark_value <= csr_wdata[ncth_pkg::MARK_BITS-1:0];
         endcase
      end
   end

   ncth_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd_ctrl    (cmd_ctrl),
      .cmd_addr    (cmd_addr),
      .cmd_ready   (!q_full)
   );

   ncth_fifo #(
      .WIDTH (QW),
      .DEPTH (ncth_pkg::CMD_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_valid),
      .push_data  ({cmd_ctrl, cmd_addr}),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   assign q_ctrl = ncth_pkg::cmd_ctrl_type'(q_head[QW-1:CW]);
   assign q_addr = q_head[CW-1:0];

   ncth_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .count_threshold (cfg_ff.count_threshold),
      .mark_value      (cfg_ff.mark_value),
      .cmd_valid       (q_valid),
      .cmd_ctrl        (q_ctrl),
      .cmd_addr        (q_addr),
      .cmd_pop         (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== hdl/ncth_checker.sv =====
// Port-level checks of the 3x3 neighbor count threshold core, bound to the top level.
// Depends on ncth_pkg and neighbor_count_threshold_3x3_core_defines.svh.
`default_nettype none
`include "neighbor_count_threshold_3x3_core_defines.svh"

module ncth_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire ncth_pkg::rsp_payload_type rsp_payload
);

   `NCTH_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && req_ready, "not idle after reset")
   `NCTH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled result changed")
   `NCTH_ASSERT_SAME(a_rsp_drop, clock, reset, $fell(rsp_valid), $past(rsp_ready), "result dropped without transfer")
   `NCTH_ASSERT_SAME(a_backpressure, clock, reset, !req_ready, $past(rsp_valid && !rsp_ready), "input stalled without output stall")

endmodule

bind neighbor_count_threshold_3x3_core ncth_checker u_ncth_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
